// ===== sv/mqf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package mqf_pkg;

	localparam int NUM_QUEUES  = 4;
	localparam int QUEUE_DEPTH = 16;
	localparam int ENTRY_WIDTH = 32;

	localparam int QSEL_W  = 2;
	localparam int DATA_W  = 32;
	localparam int FILL_W  = 5;
	localparam int QIDX_W  = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
	localparam int PTR_W   = $clog2(QUEUE_DEPTH);
	localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
	localparam int ADDR_W  = QIDX_W + PTR_W;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef enum logic {
		OP_PUSH = 1'b0,
		OP_POP  = 1'b1
	} op_t;

	typedef struct packed {
		logic              wr_en;
		logic              rd_en;
		logic [ADDR_W-1:0] addr;
	} mem_req_t;

	typedef struct packed {
		status_t           status;
		logic [FILL_W-1:0] fill_level;
		logic              pop_ok;
	} result_t;

	// selector wraps modulo NUM_QUEUES
	function automatic logic [QIDX_W-1:0] qwrap(input logic [QSEL_W-1:0] sel);
		logic [QSEL_W:0] v;
		v = {1'b0, sel};
		for (int i = 0; i < 4; i++) begin
			if (v >= (QSEL_W+1)'(NUM_QUEUES)) begin
				v = v - (QSEL_W+1)'(NUM_QUEUES);
			end
		end
		return QIDX_W'(v);
	endfunction

	function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] ptr);
		return (ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : ptr + 1'b1;
	endfunction

endpackage

`default_nettype wire

// ===== sv/mqf_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mqf_ram #(
	parameter int DATA_W = 32,
	parameter int ADDR_W = 6
) (
	input  wire logic              clk,
	input  wire logic              wr_en,
	input  wire logic [ADDR_W-1:0] wr_addr,
	input  wire logic [DATA_W-1:0] wr_data,
	input  wire logic              rd_en,
	input  wire logic [ADDR_W-1:0] rd_addr,
	output logic      [DATA_W-1:0] rd_data
);

	localparam int DEPTH = 1 << ADDR_W;

	logic [DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

// ===== sv/mqf_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mqf_ctrl
	import mqf_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              accept,
	input  wire logic              op,
	input  wire logic [QSEL_W-1:0] queue_sel,
	output mem_req_t               mem_req,
	output result_t                res
);

	logic [PTR_W-1:0] head_q [NUM_QUEUES];
	logic [PTR_W-1:0] tail_q [NUM_QUEUES];
	logic [CNT_W-1:0] count_q [NUM_QUEUES];

	logic [QIDX_W-1:0] q;
	logic [CNT_W-1:0]  cnt;
	logic [PTR_W-1:0]  hp;
	logic [PTR_W-1:0]  tp;
	logic              is_pop;
	logic              push_ok;
	logic              pop_ok;
	logic [CNT_W-1:0]  cnt_next;

	always_comb begin
		q        = qwrap(queue_sel);
		cnt      = count_q[q];
		hp       = head_q[q];
		tp       = tail_q[q];
		is_pop   = (op == OP_POP);
		pop_ok   = is_pop && (cnt != '0);
		push_ok  = !is_pop && (cnt < CNT_W'(QUEUE_DEPTH));
		cnt_next = cnt;
		if (pop_ok) begin
			cnt_next = cnt - 1'b1;
		end else if (push_ok) begin
			cnt_next = cnt + 1'b1;
		end

		mem_req.wr_en = accept && push_ok;
		mem_req.rd_en = accept && pop_ok;
		mem_req.addr  = is_pop ? {q, hp} : {q, tp};

		res.pop_ok     = pop_ok;
		res.fill_level = FILL_W'(cnt_next);
		if (is_pop) begin
			res.status = pop_ok ? ST_DONE : ST_EMPTY;
		end else begin
			res.status = push_ok ? ST_DONE : ST_FULL;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_QUEUES; i++) begin
				head_q[i]  <= '0;
				tail_q[i]  <= '0;
				count_q[i] <= '0;
			end
		end else if (accept) begin
			count_q[q] <= cnt_next;
			if (pop_ok) begin
				head_q[q] <= advance(hp);
			end
			if (push_ok) begin
				tail_q[q] <= advance(tp);
			end
		end
	end

	a_push_count: assert property (@(posedge clk) disable iff (!arst_n)
		accept && push_ok |=> count_q[$past(q)] == CNT_W'($past(cnt) + 1'b1))
		else $error("push did not raise fill count");

	a_pop_count: assert property (@(posedge clk) disable iff (!arst_n)
		accept && pop_ok |=> count_q[$past(q)] == CNT_W'($past(cnt) - 1'b1))
		else $error("pop did not lower fill count");

	a_one_port: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_req.wr_en && mem_req.rd_en))
		else $error("read and write in one request");

	a_refused_hold: assert property (@(posedge clk) disable iff (!arst_n)
		accept && res.status != ST_DONE |=> count_q[$past(q)] == $past(cnt)
		&& head_q[$past(q)] == $past(hp) && tail_q[$past(q)] == $past(tp))
		else $error("refused request changed queue state");

	for (genvar g = 0; g < NUM_QUEUES; g++) begin : g_bound
		a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
			count_q[g] <= CNT_W'(QUEUE_DEPTH))
			else $error("fill count beyond depth");
	end

endmodule

`default_nettype wire

// ===== sv/multi_queue_fifo_top.sv =====
`timescale 1ns / 1ps
`default_nettype none

// channel  direction  handshake            payload
// in       input      in_valid / in_stall   op, queue_sel, entry_data
// out      output     out_valid / out_stall status, head_data, fill_level
//
// One request per cycle unless stalled; results appear the cycle after acceptance.
// Queue state updates at the accepting edge; the entry memory is read or
// written at that edge and read data is registered.
// A stalled result holds; a new request is taken in the cycle the old result leaves.
// arst_n empties all queues at once; no clearing pass.

module multi_queue_fifo_top
	import mqf_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic              op,
	input  wire logic [QSEL_W-1:0] queue_sel,
	input  wire logic [DATA_W-1:0] entry_data,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic [1:0]             status,
	output logic [DATA_W-1:0]      head_data,
	output logic [FILL_W-1:0]      fill_level
);

	logic                   accept;
	mem_req_t               mem_req;
	result_t                res;
	logic [ENTRY_WIDTH-1:0] rd_data;

	logic                   valid_s1;
	result_t                res_s1;

	assign in_stall = valid_s1 && out_stall;
	assign accept   = in_valid && !in_stall;

	mqf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.op        (op),
		.queue_sel (queue_sel),
		.mem_req   (mem_req),
		.res       (res)
	);

	mqf_ram #(
		.DATA_W (ENTRY_WIDTH),
		.ADDR_W (ADDR_W)
	) u_ram (
		.clk     (clk),
		.wr_en   (mem_req.wr_en),
		.wr_addr (mem_req.addr),
		.wr_data (ENTRY_WIDTH'(entry_data)),
		.rd_en   (mem_req.rd_en),
		.rd_addr (mem_req.addr),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (!out_stall) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_s1 <= res;
		end
	end

	assign out_valid  = valid_s1;
	assign status     = res_s1.status;
	assign fill_level = res_s1.fill_level;
	assign head_data  = res_s1.pop_ok ? DATA_W'(rd_data) : '0;

endmodule

`default_nettype wire

// ===== tb/mqf_checker.sv =====
`timescale 1ns / 1ps

module mqf_checker
	import mqf_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	input  wire logic              in_stall,
	input  wire logic              op,
	input  wire logic [QSEL_W-1:0] queue_sel,
	input  wire logic [DATA_W-1:0] entry_data,
	input  wire logic              out_valid,
	input  wire logic              out_stall,
	input  wire logic [1:0]        status,
	input  wire logic [DATA_W-1:0] head_data,
	input  wire logic [FILL_W-1:0] fill_level,
	output int                     errors,
	output int                     pending
);

	typedef struct packed {
		status_t           status;
		logic [DATA_W-1:0] head;
		logic [FILL_W-1:0] fill;
	} reply_t;

	logic [ENTRY_WIDTH-1:0] slots [NUM_QUEUES][QUEUE_DEPTH];
	int unsigned            rd_ptr [NUM_QUEUES];
	int unsigned            wr_ptr [NUM_QUEUES];
	int unsigned            level  [NUM_QUEUES];
	reply_t                 replies_due [$];
	int                     fails;

	assign errors = fails;

	function automatic int unsigned next_slot(input int unsigned p);
		return (p + 1 >= QUEUE_DEPTH) ? 0 : p + 1;
	endfunction

	function automatic reply_t serve_request(input op_t kind, input logic [QSEL_W-1:0] sel,
			input logic [DATA_W-1:0] word);
		reply_t r;
		int     q;
		q = int'(sel) % NUM_QUEUES;
		r.status = ST_DONE;
		r.head   = '0;
		if (kind == OP_POP) begin
			if (level[q] == 0) begin
				r.status = ST_EMPTY;
			end else begin
				r.head    = DATA_W'(slots[q][rd_ptr[q]]);
				rd_ptr[q] = next_slot(rd_ptr[q]);
				level[q]  = level[q] - 1;
			end
		end else begin
			if (level[q] >= QUEUE_DEPTH) begin
				r.status = ST_FULL;
			end else begin
				slots[q][wr_ptr[q]] = word[ENTRY_WIDTH-1:0];
				wr_ptr[q] = next_slot(wr_ptr[q]);
				level[q]  = level[q] + 1;
			end
		end
		r.fill = FILL_W'(level[q]);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		reply_t want;
		if (!arst_n) begin
			for (int i = 0; i < NUM_QUEUES; i++) begin
				rd_ptr[i] = 0;
				wr_ptr[i] = 0;
				level[i]  = 0;
			end
			replies_due.delete();
			fails = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (replies_due.size() == 0) begin
					fails++;
					if (fails <= 10)
						$display("%0t: result with no request %0d/%h/%0d",
							$realtime, status, head_data, fill_level);
				end else begin
					want = replies_due.pop_front();
					if (status !== want.status || head_data !== want.head
							|| fill_level !== want.fill) begin
						fails++;
						if (fails <= 10)
							$display("%0t: exp %0d/%h/%0d got %0d/%h/%0d",
								$realtime, want.status, want.head, want.fill,
								status, head_data, fill_level);
					end
				end
			end
			if (in_valid && !in_stall)
				replies_due.push_back(serve_request(op_t'(op), queue_sel, entry_data));
		end
		pending = replies_due.size();
	end

endmodule

// ===== tb/tb_multi_queue_fifo_top.sv =====
`timescale 1ns / 1ps

module tb_multi_queue_fifo_top;
	import mqf_pkg::*;

	localparam int RANDOM_REQS = 1725;
	localparam int QUIET_LIMIT = 5000;

	logic              clk        = 1'b0;
	logic              arst_n     = 1'b0;
	logic              in_valid   = 1'b0;
	logic              op         = 1'b0;
	logic [QSEL_W-1:0] queue_sel  = '0;
	logic [DATA_W-1:0] entry_data = '0;
	logic              out_stall  = 1'b0;
	logic              calm       = 1'b0;
	wire logic         in_stall;
	wire logic         out_valid;
	wire logic [1:0]   status;
	wire logic [DATA_W-1:0] head_data;
	wire logic [FILL_W-1:0] fill_level;
	int                errors;
	int                pending;
	int                quiet = 0;

	multi_queue_fifo_top dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.op         (op),
		.queue_sel  (queue_sel),
		.entry_data (entry_data),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.status     (status),
		.head_data  (head_data),
		.fill_level (fill_level)
	);

	mqf_checker checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.op         (op),
		.queue_sel  (queue_sel),
		.entry_data (entry_data),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.status     (status),
		.head_data  (head_data),
		.fill_level (fill_level),
		.errors     (errors),
		.pending    (pending)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	always @(posedge clk) begin
		if (!arst_n)
			out_stall <= 1'b0;
		else
			out_stall <= !calm && ($urandom_range(0, 99) < 33);
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= QUIET_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// called at a rising edge; returns at the edge that takes the request
	task automatic send_req(input op_t kind, input logic [QSEL_W-1:0] sel,
			input logic [DATA_W-1:0] word);
		while (!calm && $urandom_range(0, 99) < 33) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid   <= 1'b1;
		op         <= kind;
		queue_sel  <= sel;
		entry_data <= word;
		@(negedge clk);
		while (in_stall)
			@(negedge clk);
		@(posedge clk);
	endtask

	initial begin
		int   sent;
		int   burst;
		int   push_pct;
		int   focus;
		bit   spread;
		op_t  kind;
		logic [QSEL_W-1:0] sel;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// pops on empty queues, data ignored
		for (int q = 0; q < NUM_QUEUES; q++)
			send_req(OP_POP, QSEL_W'(q), '1);
		send_req(OP_PUSH, 2'd1, '0);
		send_req(OP_PUSH, 2'd1, '1);
		send_req(OP_POP, 2'd1, '0);
		send_req(OP_POP, 2'd1, '1);
		// fill one queue, then push on full
		for (int i = 0; i <= QUEUE_DEPTH; i++)
			send_req(OP_PUSH, 2'd2, $urandom);

		sent = 0;
		while (sent < RANDOM_REQS) begin
			burst  = $urandom_range(8, 48);
			focus  = $urandom_range(0, NUM_QUEUES - 1);
			spread = $urandom_range(0, 1);
			case ($urandom_range(0, 2))
				0: push_pct = 10;
				1: push_pct = 50;
				default: push_pct = 90;
			endcase
			for (int i = 0; i < burst && sent < RANDOM_REQS; i++) begin
				calm <= (sent >= 700 && sent < 1000);
				sel  = spread ? QSEL_W'($urandom_range(0, 3)) : QSEL_W'(focus);
				kind = ($urandom_range(0, 99) < push_pct) ? OP_PUSH : OP_POP;
				send_req(kind, sel, $urandom);
				sent++;
			end
		end
		in_valid <= 1'b0;
		calm     <= 1'b0;

		do
			@(negedge clk);
		while (pending != 0);
		repeat (8) @(posedge clk);
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
